/* rtl/olis_pkg.sv */
// shared types and constants for the ordered list with insert and search
package olis_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int IDX_W    = $clog2(CAPACITY + 1);

    // operation codes carried in the request
    typedef enum logic [2:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DISPLAY   = 3'd3,
        OP_SEARCH    = 3'd4
    } t_op;

    // response status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_DISP = 1'b1
    } t_state;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [IDX_W-1:0]   position;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [IDX_W-1:0]   match_index;
        logic signed [31:0] element;
        logic [IDX_W-1:0]   element_index;
        logic               last;
    } t_rsp;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               ins_en;
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] value;
        logic [IDX_W-1:0]   length;
    } t_cell_ctl;

endpackage

/* rtl/olis_cell.sv */
// one list cell: holds one element, shifts in from its left neighbor, compares with the key
module olis_cell (
    input  logic                          i_clk,
    input  olis_pkg::t_cell_ctl           i_ctl,
    input  logic [olis_pkg::SLOT_W-1:0]   i_slot_id,
    input  logic signed [31:0]            i_left,
    output logic signed [31:0]            o_data,
    output logic                          o_match
);

    logic signed [31:0] r_data;

    // insert: take the new value at the target slot, shift back behind it
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_en) begin
            if (i_slot_id == i_ctl.slot) begin
                r_data <= i_ctl.value;
            end else if (i_slot_id > i_ctl.slot) begin
                r_data <= i_left;
            end
        end
    end

    // occupied cell holding the key
    assign o_match = ({1'b0, i_slot_id} < (olis_pkg::SLOT_W + 1)'(i_ctl.length))
                     && (r_data == i_ctl.value);
    assign o_data  = r_data;

endmodule

/* rtl/ordered_list_insert_search_top.sv */
// top level of the ordered list: cell chain, controller and response register
//
//  channel   direction  payload            handshake
//  request   in         i_req  (t_req)     i_req_valid / o_req_stall
//  response  out        o_rsp  (t_rsp)     o_rsp_valid / i_rsp_stall
//
// insert, search and unused codes each give one response; display of an empty
// list gives one response, otherwise one response per cycle while i_rsp_stall is
// low, list length responses in all; requests stall until the last is loaded
// the response register is a single stage: a new request is taken while the
// previous response is being accepted in the same cycle
// reset (synchronous, active low) empties the list; cell contents are not cleared
module ordered_list_insert_search_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  olis_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output olis_pkg::t_rsp o_rsp
);

    localparam int N  = olis_pkg::CAPACITY;
    localparam int SW = olis_pkg::SLOT_W;
    localparam int IW = olis_pkg::IDX_W;

    olis_pkg::t_state    r_state, n_state;
    logic [IW-1:0]       r_len, n_len;
    logic [SW-1:0]       r_cnt, n_cnt;
    logic                r_out_valid;
    olis_pkg::t_rsp      r_rsp, n_rsp;

    logic                w_out_free;
    logic                w_accept;
    logic                w_load;
    logic                w_ins_en;
    logic [SW-1:0]       w_slot;
    logic                w_disp_last;
    logic                w_hit;
    logic [SW-1:0]       w_first;
    olis_pkg::t_cell_ctl w_ctl;
    logic signed [31:0]  w_data [N];
    logic [N-1:0]        w_match;

    assign w_out_free  = !r_out_valid || !i_rsp_stall;
    assign w_accept    = i_req_valid && !o_req_stall;
    assign w_disp_last = ((IW)'(r_cnt) + (IW)'(1)) == r_len;

    // broadcast to the cells
    always_comb begin
        w_ctl.ins_en = w_ins_en;
        w_ctl.slot   = w_slot;
        w_ctl.value  = i_req.value;
        w_ctl.length = r_len;
    end

    // chain of cells, each fed by its left neighbor, the head by the request value
    for (genvar k = 0; k < N; k++) begin : g_cell
        logic signed [31:0] w_left;
        if (k == 0) begin : g_head
            assign w_left = i_req.value;
        end else begin : g_body
            assign w_left = w_data[k-1];
        end
        olis_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_slot_id (SW'(k)),
            .i_left    (w_left),
            .o_data    (w_data[k]),
            .o_match   (w_match[k])
        );
    end

    // first matching cell
    always_comb begin
        w_hit   = |w_match;
        w_first = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_first = SW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olis_pkg::S_IDLE: begin
                if (w_accept && i_req.opcode == olis_pkg::OP_DISPLAY && r_len != '0) begin
                    n_state = olis_pkg::S_DISP;
                end
            end
            olis_pkg::S_DISP: begin
                if (w_out_free && w_disp_last) begin
                    n_state = olis_pkg::S_IDLE;
                end
            end
            default: n_state = olis_pkg::S_IDLE;
        endcase
    end

    // outputs of the controller: stall, cell update, response and counters
    always_comb begin
        o_req_stall = (r_state != olis_pkg::S_IDLE) || !w_out_free;
        w_load      = 1'b0;
        w_ins_en    = 1'b0;
        w_slot      = '0;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_rsp       = '0;
        n_rsp.last  = 1'b1;
        unique case (r_state)
            olis_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    n_cnt  = '0;
                    unique case (i_req.opcode) inside
                        olis_pkg::OP_INS_FIRST, olis_pkg::OP_INS_END: begin
                            if (r_len >= IW'(N)) begin
                                n_rsp.status = olis_pkg::ST_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                w_slot   = (i_req.opcode == olis_pkg::OP_INS_FIRST)
                                           ? '0 : SW'(r_len);
                            end
                        end
                        olis_pkg::OP_INS_AT: begin
                            if (r_len == '0) begin
                                n_rsp.status = olis_pkg::ST_EMPTY;
                            end else if (i_req.position == '0 || i_req.position > r_len) begin
                                n_rsp.status = olis_pkg::ST_RANGE;
                            end else if (r_len >= IW'(N)) begin
                                n_rsp.status = olis_pkg::ST_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                w_slot   = SW'(i_req.position - IW'(1));
                            end
                        end
                        olis_pkg::OP_DISPLAY: begin
                            // empty list answers at once, otherwise streaming starts
                            if (r_len == '0) begin
                                n_rsp.status = olis_pkg::ST_EMPTY;
                            end else begin
                                w_load = 1'b0;
                            end
                        end
                        olis_pkg::OP_SEARCH: begin
                            if (r_len == '0) begin
                                n_rsp.status = olis_pkg::ST_EMPTY;
                            end else if (w_hit) begin
                                n_rsp.found       = 1'b1;
                                n_rsp.match_index = IW'(w_first) + IW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (w_ins_en) begin
                        n_len = r_len + IW'(1);
                    end
                end
            end
            olis_pkg::S_DISP: begin
                if (w_out_free) begin
                    w_load              = 1'b1;
                    n_rsp.element       = w_data[r_cnt];
                    n_rsp.element_index = IW'(r_cnt) + IW'(1);
                    n_rsp.last          = w_disp_last;
                    n_cnt               = r_cnt + SW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olis_pkg::S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    // list length stays within capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= IW'(N))
        else $error("list length beyond capacity");

    // streaming only happens over a non-empty list
    a_disp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == olis_pkg::S_DISP |-> r_len != '0)
        else $error("display of an empty list");

    // a successful insert grows the list by exactly one
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_en |=> r_len == $past(r_len) + IW'(1))
        else $error("insert did not grow the list");

    // a reported match points inside the list
    a_match_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.found |->
            o_rsp.match_index != '0 && o_rsp.match_index <= r_len)
        else $error("match index outside the list");

endmodule

/* tb/ordered_list_insert_search_top_tb.sv */
// self-checking testbench for the ordered list with insert, display and search
`timescale 1ns / 1ps

module ordered_list_insert_search_top_tb;

    localparam int          WATCH_LIMIT    = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          RANDOM_ITEMS   = 350;
    localparam int          HOLD_CYCLES    = 100;
    localparam int          HOLD_AFTER_RSP = 300;
    localparam int          IW             = olis_pkg::IDX_W;
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

    // shadow copy of the list and the responses still owed by the block
    class list_tracker;
        logic signed [31:0] slots [olis_pkg::CAPACITY];
        int unsigned        count;
        olis_pkg::t_rsp     awaited [$];
        int unsigned        mismatches;
        int unsigned        checked;

        function new();
            count      = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // place v at zero-based slot at, later elements move back
        function void shift_in(int unsigned at, logic signed [31:0] v);
            for (int unsigned i = count; i > at; i--)
                slots[i] = slots[i - 1];
            slots[at] = v;
            count++;
        endfunction

        // apply an accepted request and queue the responses it must give
        function void note_request(olis_pkg::t_req r);
            olis_pkg::t_rsp rsp;
            bit             hit;
            rsp      = '0;
            rsp.last = 1'b1;
            hit      = 1'b0;
            case (r.opcode) inside
                olis_pkg::OP_INS_FIRST, olis_pkg::OP_INS_END: begin
                    if (count >= olis_pkg::CAPACITY)
                        rsp.status = olis_pkg::ST_FULL;
                    else
                        shift_in((r.opcode == olis_pkg::OP_INS_FIRST) ? 0 : count, r.value);
                end
                olis_pkg::OP_INS_AT: begin
                    if (count == 0)
                        rsp.status = olis_pkg::ST_EMPTY;
                    else if (r.position < 1 || r.position > count)
                        rsp.status = olis_pkg::ST_RANGE;
                    else if (count >= olis_pkg::CAPACITY)
                        rsp.status = olis_pkg::ST_FULL;
                    else
                        shift_in(r.position - 1, r.value);
                end
                olis_pkg::OP_DISPLAY: begin
                    if (count == 0) begin
                        rsp.status = olis_pkg::ST_EMPTY;
                    end else begin
                        // one response per element, last one flagged
                        for (int unsigned i = 0; i < count; i++) begin
                            rsp               = '0;
                            rsp.element       = slots[i];
                            rsp.element_index = IW'(i + 1);
                            rsp.last          = (i + 1 == count);
                            if (i + 1 < count)
                                awaited.push_back(rsp);
                        end
                    end
                end
                olis_pkg::OP_SEARCH: begin
                    if (count == 0) begin
                        rsp.status = olis_pkg::ST_EMPTY;
                    end else begin
                        // first matching position wins
                        for (int unsigned i = 0; i < count; i++) begin
                            if (!hit && slots[i] == r.value) begin
                                hit             = 1'b1;
                                rsp.found       = 1'b1;
                                rsp.match_index = IW'(i + 1);
                            end
                        end
                    end
                end
                default: ;
            endcase
            awaited.push_back(rsp);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // compare an accepted response with the oldest one owed
        function void check_response(olis_pkg::t_rsp got);
            olis_pkg::t_rsp want;
            checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected response, expected none, actual %p", $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("found", want.found, got.found);
            compare_field("match_index", want.match_index, got.match_index);
            compare_field("element", want.element, got.element);
            compare_field("element_index", want.element_index, got.element_index);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    olis_pkg::t_req req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    olis_pkg::t_rsp rsp;

    list_tracker tracker   = new();
    int          burst_left = 0;
    int          quiet_cycles = 0;

    ordered_list_insert_search_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp)
    );

    always #5 clk = ~clk;

    // value mix: extremes, a small band that repeats, and full-range noise
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7)) inside
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    // offer one request in bursts with random gaps, return once it is taken
    task automatic offer_request(input logic [2:0] op, input logic signed [31:0] val,
                                 input logic [IW-1:0] pos);
        olis_pkg::t_req r;
        int             gap;
        r.opcode   = op;
        r.value    = val;
        r.position = pos;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        tracker.note_request(r);
    endtask

    // response side: stall pattern in modes, plus one long hold-off
    initial begin : rsp_side
        int mode;
        int mode_left;
        int hold;
        bit held;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && tracker.checked >= HOLD_AFTER_RSP) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                rsp_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // check every accepted response
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_response(rsp);
    end

    // watchdog on cycles with no request or response taken
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // request side: reset, directed cases, random traffic, drain
    initial begin : req_side
        bit                 grow;
        int                 roll;
        logic [2:0]         op;
        logic signed [31:0] val;
        logic [IW-1:0]      pos;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list
        offer_request(olis_pkg::OP_DISPLAY, 0, 0);
        offer_request(olis_pkg::OP_SEARCH, 0, 0);
        offer_request(olis_pkg::OP_INS_AT, 5, 1);
        // build a short list at both ends and in the middle
        offer_request(olis_pkg::OP_INS_FIRST, 32'sh8000_0000, 0);
        offer_request(olis_pkg::OP_INS_END, 32'sh7fff_ffff, 0);
        offer_request(olis_pkg::OP_INS_AT, -1, 1);
        offer_request(olis_pkg::OP_INS_AT, 0, 3);
        // positions below and above the list
        offer_request(olis_pkg::OP_INS_AT, 7, 0);
        offer_request(olis_pkg::OP_INS_AT, 7, 5);
        offer_request(olis_pkg::OP_INS_AT, 7, 31);
        // duplicate value, first match must be reported
        offer_request(olis_pkg::OP_INS_END, -1, 0);
        offer_request(olis_pkg::OP_SEARCH, -1, 0);
        offer_request(olis_pkg::OP_SEARCH, 32'sh7fff_ffff, 0);
        offer_request(olis_pkg::OP_SEARCH, 12345, 0);
        offer_request(olis_pkg::OP_DISPLAY, 0, 0);
        offer_request(OP_SPARE_FIRST, 32'shffff_ffff, 5'd31);
        offer_request(OP_SPARE_LAST, 0, 0);

        // random traffic: slow growth, forced fill late, then full-list work
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (tracker.count >= olis_pkg::CAPACITY)
                grow = ($urandom_range(0, 3) == 0);
            else if (k < RANDOM_ITEMS / 2)
                grow = ($urandom_range(0, 9) == 0);
            else
                grow = ($urandom_range(0, 4) < 3);
            val = pick_value();
            pos = IW'($urandom_range(0, 31));
            if (grow) begin
                roll = $urandom_range(0, 2);
                op   = (roll == 0) ? olis_pkg::OP_INS_FIRST
                     : (roll == 1) ? olis_pkg::OP_INS_END : olis_pkg::OP_INS_AT;
                if (op == olis_pkg::OP_INS_AT && tracker.count > 0
                    && $urandom_range(0, 4) != 0)
                    pos = IW'($urandom_range(1, tracker.count));
            end else begin
                roll = $urandom_range(0, 9);
                if (roll < 5) begin
                    op = olis_pkg::OP_SEARCH;
                    if (tracker.count > 0 && $urandom_range(0, 4) < 3)
                        val = tracker.slots[$urandom_range(0, tracker.count - 1)];
                end else if (roll < 8) begin
                    op = olis_pkg::OP_DISPLAY;
                end else if (roll == 8) begin
                    op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end else begin
                    op = olis_pkg::OP_INS_AT;
                end
            end
            offer_request(op, val, pos);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/olis_pkg.sv
rtl/olis_cell.sv
rtl/ordered_list_insert_search_top.sv
tb/ordered_list_insert_search_top_tb.sv
